>>> hw/rtl/bls_pkg.sv
// shared constants, codes and types for the bounded lifo stack
package bls_pkg;

    // capacity of the stack in words (2 to 64)
    localparam int DEPTH   = 64;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    // result tdata: data_word, stack_empty, stack_full, padded to whole bytes
    localparam int M_DATA_W = ((WORD_W + 2 + 7) / 8) * 8;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 2'd0,
        KIND_POP     = 2'd1,
        KIND_PEEK    = 2'd2,
        KIND_DISPLAY = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // one result handed from the controller to the result stage
    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic signed [WORD_W-1:0] word;
        logic                     from_ram;
        logic                     empty;
        logic                     full;
        logic                     last;
    } issue_t;

endpackage

>>> hw/rtl/bounded_lifo_stack.sv
// top level of the bounded lifo stack
//
//  channel  | direction | tdata (low bit up)                          | tuser  | tlast
//  s_       | in        | push_value[31:0]                            | kind   | -
//  m_       | out       | data_word[31:0], stack_empty, stack_full, 0 | status | last_result
//
// push, pop and peek each give one result; it is registered and shows in the cycle after its request is taken.
// display gives one result per stored word (a single result when empty); s_tready is low meanwhile.
// throughput is set by the single ram port pair: one access per cycle while the result register is free.
// a stall on m_tready holds the result register and, through it, s_tready.
// after reset the stack is empty and requests are accepted at once.
module bounded_lifo_stack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bls_pkg::WORD_W-1:0]    s_tdata,   // push_value
    input  logic [bls_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bls_pkg::M_DATA_W-1:0]  m_tdata,   // data_word, stack_empty, stack_full, pad
    output logic [bls_pkg::STAT_W-1:0]    m_tuser,   // status
    output logic                          m_tlast
);
    import bls_pkg::*;

    issue_t            issue;
    logic              slot_free;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // request decode and fill count
    bls_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .slot_free (slot_free),
        .issue     (issue),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    // word store
    bls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register
    bls_resp u_resp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .ram_rdata (ram_rdata),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hw/rtl/bls_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module bls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port; read data holds between reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bls_ctrl.sv
// stack controller: fill count, request decode, display sequencer, ram access
module bls_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bls_pkg::WORD_W-1:0]    s_tdata,
    input  logic [bls_pkg::KIND_W-1:0]    s_tuser,
    input  logic                          slot_free,
    output bls_pkg::issue_t               issue,
    output logic                          ram_we,
    output logic [bls_pkg::ADDR_W-1:0]    ram_waddr,
    output logic [bls_pkg::WORD_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [bls_pkg::ADDR_W-1:0]    ram_raddr
);
    import bls_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              disp_reg, disp_next;
    logic [ADDR_W-1:0] disp_addr_reg, disp_addr_next;
    logic              s_fire;
    logic              is_empty, is_full;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  cnt_inc;

    assign s_tready = slot_free && !disp_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg == CNT_W'(DEPTH));
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign ram_wdata = s_tdata;

    // request decode and display stepping
    always_comb begin
        cnt_next       = cnt_reg;
        disp_next      = disp_reg;
        disp_addr_next = disp_addr_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_re         = 1'b0;
        ram_raddr      = cnt_dec[ADDR_W-1:0];
        issue          = '0;
        issue.status   = ST_OK;
        issue.last     = 1'b1;

        if (disp_reg && slot_free) begin
            // one stored word per transfer, top down
            issue.valid = 1'b1;
            issue.from_ram = 1'b1;
            ram_re      = 1'b1;
            ram_raddr   = disp_addr_reg;
            issue.last  = (disp_addr_reg == '0);
            if (disp_addr_reg == '0) begin
                disp_next = 1'b0;
            end else begin
                disp_addr_next = disp_addr_reg - ADDR_W'(1);
            end
        end else if (s_fire) begin
            issue.valid = 1'b1;
            unique case (kind_t'(s_tuser))
                KIND_PUSH: begin
                    if (is_full) begin
                        issue.status = ST_OVERFLOW;
                    end else begin
                        ram_we     = 1'b1;
                        cnt_next   = cnt_inc;
                        issue.word = s_tdata;
                    end
                end
                KIND_POP: begin
                    if (is_empty) begin
                        issue.status = ST_EMPTY;
                    end else begin
                        ram_re         = 1'b1;
                        issue.from_ram = 1'b1;
                        cnt_next       = cnt_dec;
                    end
                end
                KIND_PEEK: begin
                    if (is_empty) begin
                        issue.status = ST_EMPTY;
                    end else begin
                        ram_re         = 1'b1;
                        issue.from_ram = 1'b1;
                    end
                end
                KIND_DISPLAY: begin
                    if (is_empty) begin
                        issue.status = ST_EMPTY;
                    end else begin
                        ram_re         = 1'b1;
                        issue.from_ram = 1'b1;
                        issue.last     = (cnt_reg == CNT_W'(1));
                        if (cnt_reg != CNT_W'(1)) begin
                            disp_next      = 1'b1;
                            disp_addr_next = cnt_dec[ADDR_W-1:0] - ADDR_W'(1);
                        end
                    end
                end
                default: begin
                    issue.status = ST_EMPTY;
                end
            endcase
        end

        // flags describe the stack after this step
        issue.empty = (cnt_next == '0);
        issue.full  = (cnt_next == CNT_W'(DEPTH));
    end

    // fill count and display sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            disp_reg      <= 1'b0;
            disp_addr_reg <= '0;
        end else begin
            cnt_reg       <= cnt_next;
            disp_reg      <= disp_next;
            disp_addr_reg <= disp_addr_next;
        end
    end

`ifndef NO_ASSERTIONS
    // count never passes capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // a single ram access per cycle
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("ram read and write in the same cycle");

    // a successful pop lowers the count by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == KIND_POP && !is_empty) |=> (cnt_reg == $past(cnt_dec)))
        else $error("pop did not lower the fill count");

    // display never changes the count
    a_disp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        disp_reg |=> $stable(cnt_reg))
        else $error("fill count moved during display");
`endif

endmodule

>>> hw/rtl/bls_resp.sv
// result stage: holds one result until its transfer, word taken from ram or register
module bls_resp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bls_pkg::issue_t               issue,
    input  logic [bls_pkg::WORD_W-1:0]    ram_rdata,
    output logic                          slot_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bls_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [bls_pkg::STAT_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import bls_pkg::*;

    logic                     valid_reg;
    status_t                  status_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic                     from_ram_reg;
    logic                     empty_reg;
    logic                     full_reg;
    logic                     last_reg;
    logic [WORD_W-1:0]        data_word;

    assign slot_free = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= issue.valid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (slot_free && issue.valid) begin
            status_reg   <= issue.status;
            word_reg     <= issue.word;
            from_ram_reg <= issue.from_ram;
            empty_reg    <= issue.empty;
            full_reg     <= issue.full;
            last_reg     <= issue.last;
        end
    end

    // ram data holds until the next read, which only comes once this result is gone
    assign data_word = from_ram_reg ? ram_rdata : word_reg;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {{(M_DATA_W - WORD_W - 2){1'b0}}, full_reg, empty_reg, data_word};
    assign m_tuser   = status_reg;
    assign m_tlast   = last_reg;

`ifndef NO_ASSERTIONS
    // a stalled result is never overwritten by a new one
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_tready) |-> !slot_free)
        else $error("result stage overrun");
`endif

endmodule

>>> tb/bounded_lifo_stack_test.sv
// self-checking testbench for the bounded lifo stack: directed and random requests with flow control
module bounded_lifo_stack_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    // one expected or observed result transfer
    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   word;
        logic                empty;
        logic                full;
        logic                last;
    } stack_result_t;

    // shadow stack, expected result queue and mismatch count
    class stack_scoreboard;
        logic [WORD_W-1:0] shadow_words [DEPTH];
        int                shadow_fill;
        stack_result_t     expected_results [$];
        int                errors;

        function new();
            shadow_fill = 0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void add_result(status_t status, logic [WORD_W-1:0] word, logic last);
            stack_result_t r;
            r.status = status;
            r.word   = word;
            r.empty  = (shadow_fill == 0);
            r.full   = (shadow_fill >= DEPTH);
            r.last   = last;
            expected_results.push_back(r);
        endfunction

        // work out every result caused by one accepted request
        function void note_request(kind_t kind, logic [WORD_W-1:0] value);
            case (kind)
                KIND_PUSH: begin
                    if (shadow_fill >= DEPTH) begin
                        add_result(ST_OVERFLOW, '0, 1'b1);
                    end else begin
                        shadow_words[shadow_fill] = value;
                        shadow_fill++;
                        add_result(ST_OK, value, 1'b1);
                    end
                end
                KIND_POP: begin
                    if (shadow_fill == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        shadow_fill--;
                        add_result(ST_OK, shadow_words[shadow_fill], 1'b1);
                    end
                end
                KIND_PEEK: begin
                    if (shadow_fill == 0)
                        add_result(ST_EMPTY, '0, 1'b1);
                    else
                        add_result(ST_OK, shadow_words[shadow_fill-1], 1'b1);
                end
                default: begin
                    // display walks from the top word down to the bottom one
                    if (shadow_fill == 0) begin
                        add_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = shadow_fill; i > 0; i--)
                            add_result(ST_OK, shadow_words[i-1], i == 1);
                    end
                end
            endcase
        endfunction

        task report(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            $display("mismatch on %s at %0t: got %h, want %h", field, $realtime, got, want);
            errors++;
        endtask

        // compare one result transfer with the oldest expectation
        task check_result(stack_result_t got);
            stack_result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected result", got.word, '0);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report("status", WORD_W'(got.status), WORD_W'(want.status));
                if (got.word !== want.word)
                    report("data_word", got.word, want.word);
                if (got.empty !== want.empty)
                    report("stack_empty", WORD_W'(got.empty), WORD_W'(want.empty));
                if (got.full !== want.full)
                    report("stack_full", WORD_W'(got.full), WORD_W'(want.full));
                if (got.last !== want.last)
                    report("last_result", WORD_W'(got.last), WORD_W'(want.last));
            end
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata  = '0;     // push_value
    logic [KIND_W-1:0]    s_tuser  = '0;     // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;           // data_word, stack_empty, stack_full, pad
    logic [STAT_W-1:0]    m_tuser;           // status
    logic                 m_tlast;

    stack_scoreboard sb = new();
    int              hold_cycles = 0;
    int              burst_left  = 0;

    bounded_lifo_stack u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: long hold-off on request, else a stall rate that changes now and then
    int stall_pct = 0;
    int rate_age  = 0;
    always @(posedge aclk) begin
        if (rate_age == 0) begin
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            rate_age = $urandom_range(8, 48);
        end
        rate_age--;
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        stack_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tuser);
            got.word   = m_tdata[WORD_W-1:0];
            got.empty  = m_tdata[WORD_W];
            got.full   = m_tdata[WORD_W+1];
            got.last   = m_tlast;
            sb.check_result(got);
        end
    end

    // hold one request on the input until its transfer, then log it
    task send_request(kind_t kind, logic [WORD_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(kind, value);
    endtask

    // sender in bursts with random gaps between them
    task offer(kind_t kind, logic [WORD_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        send_request(kind, value);
        burst_left--;
    endtask

    // stop offering until every expected result has come back
    task wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // main stimulus
    initial begin
        int                mode;
        int                run_left;
        int                pick;
        kind_t             kind;
        logic [WORD_W-1:0] value;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme words, every operation, empty-stack cases
        offer(KIND_PUSH, 32'h8000_0000);
        offer(KIND_PUSH, 32'h7fff_ffff);
        offer(KIND_PUSH, 32'h0000_0000);
        offer(KIND_PUSH, 32'hffff_ffff);
        offer(KIND_PEEK, '0);
        offer(KIND_DISPLAY, '0);
        repeat (4) offer(KIND_POP, '0);
        offer(KIND_POP, '0);
        offer(KIND_PEEK, '0);
        offer(KIND_DISPLAY, '0);
        offer(KIND_PUSH, 32'h5555_5555);
        offer(KIND_PUSH, 32'haaaa_aaaa);
        offer(KIND_DISPLAY, '0);
        offer(KIND_POP, '0);
        offer(KIND_POP, '0);
        wait_all_results();

        // receiver holds off while pushes keep coming: input stalls, stack fills, overflows
        hold_cycles = 300;
        repeat (DEPTH + 3) send_request(KIND_PUSH, $urandom);
        offer(KIND_PEEK, '0);
        offer(KIND_DISPLAY, '0);
        repeat (DEPTH + 2) offer(KIND_POP, '0);
        wait_all_results();

        // random runs that grow, shrink or mix the stack
        run_left = 0;
        mode     = 0;
        repeat (50) begin
            if (run_left == 0) begin
                mode     = $urandom_range(2);
                run_left = $urandom_range(5, 40);
            end
            run_left--;
            pick = $urandom_range(99);
            case (mode)
                0:       kind = (pick < 75) ? KIND_PUSH : (pick < 85) ? KIND_POP :
                                (pick < 95) ? KIND_PEEK : KIND_DISPLAY;
                1:       kind = (pick < 70) ? KIND_POP : (pick < 85) ? KIND_PUSH :
                                (pick < 95) ? KIND_PEEK : KIND_DISPLAY;
                default: kind = kind_t'(pick % 4);
            endcase
            case ($urandom_range(7))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7fff_ffff;
                2:       value = (pick[0]) ? 32'h0 : 32'hffff_ffff;
                default: value = $urandom;
            endcase
            offer(kind, value);
        end

        // finish: drain and give the block time to show any stray result
        wait_all_results();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_ram.sv
hw/rtl/bls_ctrl.sv
hw/rtl/bls_resp.sv
hw/rtl/bounded_lifo_stack.sv
tb/bounded_lifo_stack_test.sv
